### src/pbl_pkg.sv
// Shared types and constants for the palette scanline blitter.
// Used by every module under src; depends on nothing.
`default_nettype none

package pbl_pkg;

    localparam int SCREEN_WIDTH_DEF  = 360;
    localparam int SCREEN_HEIGHT_DEF = 360;

    localparam int ADDR_W    = 17;
    localparam int COLOR_W   = 16;
    localparam int DEST_W    = 18;
    localparam int POS_W     = 19;
    localparam int COORD_W   = 16;
    localparam int INDEX_W   = 8;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ROW   = 2'd1,
        OP_PIXEL = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 1'b0,
        CFG_OFFSET_Y = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } pix_req_t;

endpackage

`default_nettype wire

### src/palette_scanline_blit.sv
// Top level of the palette scanline blitter.
// Depends on pbl_pkg, pbl_row_ctrl, pbl_palette_ram and pbl_out_pipe.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   in       | in_valid / in_stall   | opcode, palette and row fields, pixel
//   out      | out_valid / out_stall | write_address, write_color
//   cfg      | cfg_we                | cfg_index, cfg_data
//
// One word accepted per cycle while in_stall is low; a pixel write passes
// through the palette RAM read stage, then the output register.
// Reset clears row state, offsets and pipeline valids; palette is not cleared.
// out_stall holds the output register; input stalls only when both the
// read stage and the output register are full.
`default_nettype none

module palette_scanline_blit #(
    parameter int SCREEN_WIDTH  = pbl_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pbl_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pbl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pbl_pkg::COORD_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [pbl_pkg::INDEX_W-1:0]   palette_slot,
    input  wire logic [pbl_pkg::COLOR_W-1:0]   palette_color,
    input  wire logic [pbl_pkg::COORD_W-1:0]   frame_left,
    input  wire logic [pbl_pkg::COORD_W-1:0]   frame_top,
    input  wire logic [pbl_pkg::COORD_W-1:0]   row_line,
    input  wire logic [pbl_pkg::COORD_W-1:0]   row_width,
    input  wire logic                          key_enable,
    input  wire logic [pbl_pkg::INDEX_W-1:0]   key_index,
    input  wire logic [pbl_pkg::INDEX_W-1:0]   pixel_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [pbl_pkg::ADDR_W-1:0]    write_address,
    output logic      [pbl_pkg::COLOR_W-1:0]   write_color
);
    import pbl_pkg::*;

    op_t                op;
    logic               take;
    logic               a_ready;
    pix_req_t           req;
    logic [COLOR_W-1:0] rd_data;

    assign op       = op_t'(opcode);
    assign in_stall = !a_ready;
    assign take     = in_valid && a_ready;

    pbl_row_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_row_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .take        (take),
        .opcode      (op),
        .frame_left  (frame_left),
        .frame_top   (frame_top),
        .row_line    (row_line),
        .row_width   (row_width),
        .key_enable  (key_enable),
        .key_index   (key_index),
        .pixel_index (pixel_index),
        .req         (req)
    );

    pbl_palette_ram u_palette_ram (
        .clk   (clk),
        .we    (take && (op == OP_LOAD)),
        .waddr (palette_slot),
        .wdata (palette_color),
        .re    (take && req.hit),
        .raddr (pixel_index),
        .rdata (rd_data)
    );

    pbl_out_pipe u_out_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .req           (req),
        .rd_data       (rd_data),
        .out_stall     (out_stall),
        .a_ready       (a_ready),
        .out_valid     (out_valid),
        .write_address (write_address),
        .write_color   (write_color)
    );

endmodule

`default_nettype wire

### src/pbl_palette_ram.sv
// 256 x 16 palette memory, one write port and one registered read port.
// Depends on pbl_pkg.
`default_nettype none

module pbl_palette_ram (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [pbl_pkg::INDEX_W-1:0] waddr,
    input  wire logic [pbl_pkg::COLOR_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [pbl_pkg::INDEX_W-1:0] raddr,
    output logic      [pbl_pkg::COLOR_W-1:0] rdata
);
    import pbl_pkg::*;

    logic [COLOR_W-1:0] mem [0:(1 << INDEX_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/pbl_row_ctrl.sv
// Offset registers, latched row state and per-pixel clip/key decision.
// Depends on pbl_pkg.
`default_nettype none

module pbl_row_ctrl #(
    parameter int SCREEN_WIDTH  = pbl_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pbl_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pbl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pbl_pkg::COORD_W-1:0]   cfg_data,
    input  wire logic                          take,
    input  wire pbl_pkg::op_t                  opcode,
    input  wire logic [pbl_pkg::COORD_W-1:0]   frame_left,
    input  wire logic [pbl_pkg::COORD_W-1:0]   frame_top,
    input  wire logic [pbl_pkg::COORD_W-1:0]   row_line,
    input  wire logic [pbl_pkg::COORD_W-1:0]   row_width,
    input  wire logic                          key_enable,
    input  wire logic [pbl_pkg::INDEX_W-1:0]   key_index,
    input  wire logic [pbl_pkg::INDEX_W-1:0]   pixel_index,
    output pbl_pkg::pix_req_t                  req
);
    import pbl_pkg::*;

    logic [COORD_W-1:0] offset_x_reg, offset_x_next;
    logic [COORD_W-1:0] offset_y_reg, offset_y_next;
    logic [DEST_W-1:0]  dest_row_reg, dest_row_next;
    logic               row_visible_reg, row_visible_next;
    logic [COORD_W-1:0] column_count_reg, column_count_next;
    logic [COORD_W-1:0] width_held_reg, width_held_next;
    logic [COORD_W-1:0] left_held_reg, left_held_next;
    logic               key_enable_held_reg, key_enable_held_next;
    logic [INDEX_W-1:0] key_index_held_reg, key_index_held_next;

    logic [POS_W-1:0]  y_pos;
    logic [POS_W-1:0]  x_pos;
    logic              y_ok;
    logic              x_ok;
    logic [31:0]       y_prod;
    logic [DEST_W-1:0] addr_sum;
    logic              in_row;
    logic              keyed;

    // y and x are 19-bit two's complement; the top bit marks negative
    assign y_pos = {{(POS_W-COORD_W){offset_y_reg[COORD_W-1]}}, offset_y_reg}
                 + {{(POS_W-COORD_W){1'b0}}, frame_top}
                 + {{(POS_W-COORD_W){1'b0}}, row_line};
    assign x_pos = {{(POS_W-COORD_W){offset_x_reg[COORD_W-1]}}, offset_x_reg}
                 + {{(POS_W-COORD_W){1'b0}}, left_held_reg}
                 + {{(POS_W-COORD_W){1'b0}}, column_count_reg};

    assign y_ok     = !y_pos[POS_W-1] && (y_pos < POS_W'(SCREEN_HEIGHT));
    assign x_ok     = !x_pos[POS_W-1] && (x_pos < POS_W'(SCREEN_WIDTH));
    assign y_prod   = {{(32-POS_W){1'b0}}, y_pos} * 32'(SCREEN_WIDTH);
    assign addr_sum = dest_row_reg + x_pos[DEST_W-1:0];
    assign in_row   = column_count_reg < width_held_reg;
    assign keyed    = key_enable_held_reg && (pixel_index == key_index_held_reg);

    always_comb
    begin
        req.hit  = take && (opcode == OP_PIXEL) && in_row && row_visible_reg
                 && x_ok && !keyed;
        req.addr = addr_sum[ADDR_W-1:0];
    end

    always_comb
    begin
        offset_x_next        = offset_x_reg;
        offset_y_next        = offset_y_reg;
        dest_row_next        = dest_row_reg;
        row_visible_next     = row_visible_reg;
        column_count_next    = column_count_reg;
        width_held_next      = width_held_reg;
        left_held_next       = left_held_reg;
        key_enable_held_next = key_enable_held_reg;
        key_index_held_next  = key_index_held_reg;

        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_OFFSET_X: offset_x_next = cfg_data;
                CFG_OFFSET_Y: offset_y_next = cfg_data;
                default: ;
            endcase
        end

        if (take)
        begin
            case (opcode)
                OP_ROW:
                begin
                    row_visible_next     = y_ok;
                    dest_row_next        = y_ok ? y_prod[DEST_W-1:0] : '0;
                    left_held_next       = frame_left;
                    width_held_next      = row_width;
                    key_enable_held_next = key_enable;
                    key_index_held_next  = key_index;
                    column_count_next    = '0;
                end
                OP_PIXEL:
                begin
                    if (in_row)
                    begin
                        column_count_next = column_count_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg        <= '0;
            offset_y_reg        <= '0;
            dest_row_reg        <= '0;
            row_visible_reg     <= 1'b0;
            column_count_reg    <= '0;
            width_held_reg      <= '0;
            left_held_reg       <= '0;
            key_enable_held_reg <= 1'b0;
            key_index_held_reg  <= '0;
        end
        else
        begin
            offset_x_reg        <= offset_x_next;
            offset_y_reg        <= offset_y_next;
            dest_row_reg        <= dest_row_next;
            row_visible_reg     <= row_visible_next;
            column_count_reg    <= column_count_next;
            width_held_reg      <= width_held_next;
            left_held_reg       <= left_held_next;
            key_enable_held_reg <= key_enable_held_next;
            key_index_held_reg  <= key_index_held_next;
        end
    end

endmodule

`default_nettype wire

### src/pbl_out_pipe.sv
// Read stage and output register for framebuffer writes, with stall control.
// Depends on pbl_pkg; color comes from the palette RAM read port.
`default_nettype none

module pbl_out_pipe (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire pbl_pkg::pix_req_t           req,
    input  wire logic [pbl_pkg::COLOR_W-1:0] rd_data,
    input  wire logic                        out_stall,
    output logic                             a_ready,
    output logic                             out_valid,
    output logic      [pbl_pkg::ADDR_W-1:0]  write_address,
    output logic      [pbl_pkg::COLOR_W-1:0] write_color
);
    import pbl_pkg::*;

    logic              a_valid_reg, a_valid_next;
    logic [ADDR_W-1:0] a_addr_reg;
    logic              b_valid_reg, b_valid_next;
    logic [ADDR_W-1:0] b_addr_reg;
    logic [COLOR_W-1:0] b_color_reg;
    logic              adv_b;

    assign adv_b   = !b_valid_reg || !out_stall;
    assign a_ready = !a_valid_reg || adv_b;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (adv_b)
        begin
            b_valid_next = a_valid_reg;
        end
        if (a_ready)
        begin
            a_valid_next = take && req.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && req.hit)
        begin
            a_addr_reg <= req.addr;
        end
        if (adv_b && a_valid_reg)
        begin
            b_addr_reg  <= a_addr_reg;
            b_color_reg <= rd_data;
        end
    end

    assign out_valid     = b_valid_reg;
    assign write_address = b_addr_reg;
    assign write_color   = b_color_reg;

endmodule

`default_nettype wire

### tb/sv/pbl_blit_checker.sv
`timescale 1ns / 1ps
// Checker for palette_scanline_blit: follows offset writes and palette and row state from
// accepted words, predicts each framebuffer write and compares the output channel in order.
// Depends on pbl_pkg.

module pbl_blit_checker #(
    parameter int SCREEN_WIDTH  = pbl_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pbl_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pbl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pbl_pkg::COORD_W-1:0]   cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [pbl_pkg::INDEX_W-1:0]   palette_slot,
    input  logic [pbl_pkg::COLOR_W-1:0]   palette_color,
    input  logic [pbl_pkg::COORD_W-1:0]   frame_left,
    input  logic [pbl_pkg::COORD_W-1:0]   frame_top,
    input  logic [pbl_pkg::COORD_W-1:0]   row_line,
    input  logic [pbl_pkg::COORD_W-1:0]   row_width,
    input  logic                          key_enable,
    input  logic [pbl_pkg::INDEX_W-1:0]   key_index,
    input  logic [pbl_pkg::INDEX_W-1:0]   pixel_index,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [pbl_pkg::ADDR_W-1:0]    write_address,
    input  logic [pbl_pkg::COLOR_W-1:0]   write_color,
    output int                            fail_count,
    output int                            pending
);

    import pbl_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
    } fb_write_t;

    fb_write_t                fb_writes_due[$];
    fb_write_t                due;
    logic [COLOR_W-1:0]       palette_mem [256];
    logic signed [COORD_W-1:0] off_x;
    logic signed [COORD_W-1:0] off_y;
    logic [DEST_W-1:0]        row_base;
    logic                     row_on;
    logic [COORD_W-1:0]       col_q;
    logic [COORD_W-1:0]       width_q;
    logic [COORD_W-1:0]       left_q;
    logic                     key_on;
    logic [INDEX_W-1:0]       key_q;
    int                       mismatches = 0;
    int                       outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic blit_word();
        int        y;
        int        x;
        int        lin;
        fb_write_t w;
        case (op_t'(opcode))
            OP_LOAD: palette_mem[palette_slot] = palette_color;
            OP_ROW: begin
                y        = int'(off_y) + int'(frame_top) + int'(row_line);
                row_on   = (y >= 0) && (y < SCREEN_HEIGHT);
                lin      = y * SCREEN_WIDTH;
                row_base = row_on ? lin[DEST_W-1:0] : '0;
                left_q   = frame_left;
                width_q  = row_width;
                key_on   = key_enable;
                key_q    = key_index;
                col_q    = '0;
            end
            OP_PIXEL: begin
                if (col_q < width_q)
                begin
                    x     = int'(off_x) + int'(left_q) + int'(col_q);
                    col_q = col_q + 16'd1;
                    if (row_on && x >= 0 && x < SCREEN_WIDTH
                        && !(key_on && pixel_index == key_q))
                    begin
                        lin     = int'(row_base) + x;
                        w.addr  = lin[ADDR_W-1:0];
                        w.color = palette_mem[pixel_index];
                        fb_writes_due.push_back(w);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x    = '0;
            off_y    = '0;
            row_base = '0;
            row_on   = 1'b0;
            col_q    = '0;
            width_q  = '0;
            left_q   = '0;
            key_on   = 1'b0;
            key_q    = '0;
            fb_writes_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (fb_writes_due.size() == 0)
                    report_mismatch("unexpected write", int'(write_address), 0);
                else
                begin
                    due = fb_writes_due.pop_front();
                    if (write_address !== due.addr)
                        report_mismatch("write_address", int'(write_address),
                                        int'(due.addr));
                    if (write_color !== due.color)
                        report_mismatch("write_color", int'(write_color), int'(due.color));
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_OFFSET_X: off_x = cfg_data;
                    CFG_OFFSET_Y: off_y = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                blit_word();
            outstanding = fb_writes_due.size();
        end
    end

endmodule

### tb/sv/tb_palette_scanline_blit.sv
`timescale 1ns / 1ps
// Testbench top for palette_scanline_blit: clock, reset, offset settings, directed and
// random word streams with random output stalls. Depends on pbl_pkg and pbl_blit_checker.

module tb_palette_scanline_blit;

    import pbl_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 165;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           opcode;
    logic [INDEX_W-1:0]   palette_slot;
    logic [COLOR_W-1:0]   palette_color;
    logic [COORD_W-1:0]   frame_left;
    logic [COORD_W-1:0]   frame_top;
    logic [COORD_W-1:0]   row_line;
    logic [COORD_W-1:0]   row_width;
    logic                 key_enable;
    logic [INDEX_W-1:0]   key_index;
    logic [INDEX_W-1:0]   pixel_index;
    logic                 out_valid;
    logic                 out_stall;
    logic [ADDR_W-1:0]    write_address;
    logic [COLOR_W-1:0]   write_color;
    int                   fail_count;
    int                   pending;

    int                   cycle_count = 0;
    int                   words_sent = 0;
    int                   ofs_x = 0;
    int                   ofs_y = 0;
    bit                   gapless = 1'b0;
    bit                   slot_loaded [256];
    logic [INDEX_W-1:0]   loaded_slots[$];
    int                   phase_ox [PHASES] = '{180, -32768, -32768, 180, 60, -200, 0, 0};
    int                   phase_oy [PHASES] = '{180, -32768, 180, -32768, 40, 100, 0, 0};

    palette_scanline_blit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .palette_slot  (palette_slot),
        .palette_color (palette_color),
        .frame_left    (frame_left),
        .frame_top     (frame_top),
        .row_line      (row_line),
        .row_width     (row_width),
        .key_enable    (key_enable),
        .key_index     (key_index),
        .pixel_index   (pixel_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_address (write_address),
        .write_color   (write_color)
    );

    pbl_blit_checker blit_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .palette_slot  (palette_slot),
        .palette_color (palette_color),
        .frame_left    (frame_left),
        .frame_top     (frame_top),
        .row_line      (row_line),
        .row_width     (row_width),
        .key_enable    (key_enable),
        .key_index     (key_index),
        .pixel_index   (pixel_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_address (write_address),
        .write_color   (write_color),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output back-pressure: short stalls, rare long ones, long free stretches now and then
    initial
    begin
        bit stalled;
        int left_n;
        stalled = 1'b0;
        left_n  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (left_n == 0)
            begin
                if (stalled || $urandom_range(0, 1))
                begin
                    stalled = 1'b0;
                    left_n  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6)
                                                           : $urandom_range(40, 150);
                end
                else
                begin
                    stalled = 1'b1;
                    left_n  = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                           : $urandom_range(10, 40);
                end
            end
            out_stall <= stalled;
            left_n--;
        end
    end

    function automatic logic [INDEX_W-1:0] pick_loaded();
        return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
    endfunction

    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (gapless || r < 65)
            n = 0;
        else if (r < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 30);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // called right after a rising edge; returns after the edge that took the word and any idle gap
    task automatic drive_word(input op_t op, input logic [7:0] slot,
                              input logic [15:0] color, left, top, line, width,
                              input logic ken, input logic [7:0] kidx, pidx);
        in_valid      <= 1'b1;
        opcode        <= op;
        palette_slot  <= slot;
        palette_color <= color;
        frame_left    <= left;
        frame_top     <= top;
        row_line      <= line;
        row_width     <= width;
        key_enable    <= ken;
        key_index     <= kidx;
        pixel_index   <= pidx;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        words_sent++;
        idle_gap();
    endtask

    task automatic send_load(input logic [7:0] slot, input logic [15:0] color);
        if (!slot_loaded[slot])
        begin
            slot_loaded[slot] = 1'b1;
            loaded_slots.push_back(slot);
        end
        drive_word(OP_LOAD, slot, color, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), pick_loaded());
    endtask

    task automatic send_row(input logic [15:0] left, top, line, width,
                            input logic ken, input logic [7:0] kidx);
        drive_word(OP_ROW, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   left, top, line, width, ken, kidx, pick_loaded());
    endtask

    task automatic send_pixel(input logic [7:0] idx);
        drive_word(OP_PIXEL, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic send_unused_op();
        drive_word(OP_NONE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), pick_loaded());
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_offsets(input int ox, input int oy);
        wait_quiet();
        ofs_x = ox;
        ofs_y = oy;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OFFSET_X;
        cfg_data  <= ox[15:0];
        @(posedge clk);
        cfg_index <= CFG_OFFSET_Y;
        cfg_data  <= oy[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_burst();
        int n;
        int k;
        int r;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            send_load(8'($urandom_range(0, 255)),
                      (r < 5) ? 16'h0000 : (r < 10) ? 16'hFFFF
                                                    : 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic noise_burst();
        int r;
        int k;
        int n;
        r = $urandom_range(0, 99);
        if (r < 35)
            send_unused_op();
        else if (r < 70)
        begin
            send_row(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
                send_pixel(pick_loaded());
        end
        else
        begin
            n = $urandom_range(1, 2);
            for (k = 0; k < n; k++)
                send_pixel(pick_loaded());
        end
    endtask

    // a row start aimed at the screen (mostly), then its pixels, sometimes extra ones and loads
    task automatic row_episode();
        int         r;
        int         ty;
        int         tx;
        int         total;
        int         lo;
        int         hi;
        int         top_v;
        int         line_v;
        int         left_v;
        int         width_v;
        int         extra;
        int         k;
        logic       ken;
        logic [7:0] kidx;
        r = $urandom_range(0, 99);
        if (r < 85)
            ty = $urandom_range(0, 359);
        else if (r < 93)
            ty = -int'($urandom_range(1, 40));
        else
            ty = 360 + int'($urandom_range(0, 40));
        total = ty - ofs_y;
        if (total < 0 || total > 131070)
        begin
            top_v  = $urandom_range(0, 400);
            line_v = $urandom_range(0, 400);
        end
        else
        begin
            lo     = (total > 65535) ? total - 65535 : 0;
            hi     = (total > 65535) ? 65535 : total;
            top_v  = lo + int'($urandom_range(0, hi - lo));
            line_v = total - top_v;
        end
        tx     = int'($urandom_range(0, 375)) - 16;
        left_v = tx - ofs_x;
        if (left_v < 0 || left_v > 65535)
            left_v = $urandom_range(0, 400);
        r = $urandom_range(0, 99);
        if (r < 90)
            width_v = $urandom_range(1, 24);
        else if (r < 97)
            width_v = $urandom_range(25, 80);
        else
            width_v = $urandom_range(300, 400);
        ken  = 1'($urandom_range(0, 1));
        kidx = pick_loaded();
        send_row(16'(left_v), 16'(top_v), 16'(line_v), 16'(width_v), ken, kidx);
        extra = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
        for (k = 0; k < width_v + extra; k++)
        begin
            if ($urandom_range(0, 49) == 0)
                send_load(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            send_pixel(($urandom_range(0, 4) == 0) ? kidx : pick_loaded());
        end
    endtask

    task automatic random_traffic(input int count);
        int stop;
        int r;
        stop = words_sent + count;
        while (words_sent < stop)
        begin
            r       = $urandom_range(0, 99);
            gapless = ($urandom_range(0, 3) == 0);
            if (r < 12)
                load_burst();
            else if (r < 22)
                noise_burst();
            else
                row_episode();
        end
        gapless = 1'b0;
    endtask

    task automatic directed_words();
        send_load(8'h00, 16'hFFFF);
        send_load(8'hFF, 16'h0000);
        send_load(8'h55, 16'hA5A5);
        send_load(8'hAA, 16'h5A5A);
        // pixel before any row: no write
        send_pixel(8'h00);
        send_unused_op();
        // top-left corner, key on 0xAA
        send_row(16'd0, 16'd0, 16'd0, 16'd4, 1'b1, 8'hAA);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hAA);
        send_pixel(8'h55);
        send_pixel(8'h00);
        // bottom-right edge, last two columns clipped, key off
        send_row(16'd356, 16'd0, 16'd359, 16'd6, 1'b0, 8'hAA);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hAA);
        send_pixel(8'h55);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        // row below the screen
        send_row(16'd10, 16'd360, 16'd0, 16'd2, 1'b0, 8'h00);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        // empty row
        send_row(16'd0, 16'd5, 16'd5, 16'd0, 1'b0, 8'h00);
        send_pixel(8'h00);
    endtask

    initial
    begin
        int p;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_OFFSET_X;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        opcode        <= OP_NONE;
        palette_slot  <= '0;
        palette_color <= '0;
        frame_left    <= '0;
        frame_top     <= '0;
        row_line      <= '0;
        row_width     <= '0;
        key_enable    <= 1'b0;
        key_index     <= '0;
        pixel_index   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_offsets(0, 0);
        directed_words();

        phase_ox[6] = int'($urandom_range(0, 580)) - 400;
        phase_oy[6] = int'($urandom_range(0, 580)) - 400;
        phase_ox[7] = int'($urandom_range(0, 580)) - 400;
        phase_oy[7] = int'($urandom_range(0, 580)) - 400;
        for (p = 0; p < PHASES; p++)
        begin
            write_offsets(phase_ox[p], phase_oy[p]);
            random_traffic(PHASE_WORDS);
        end

        wait_quiet();
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
src/pbl_pkg.sv
src/pbl_palette_ram.sv
src/pbl_row_ctrl.sv
src/pbl_out_pipe.sv
src/palette_scanline_blit.sv
tb/sv/pbl_blit_checker.sv
tb/sv/tb_palette_scanline_blit.sv
